### src/touch_trimmed_mean_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Touch trimmed-mean filter assertion macros
// Short forms for clocked assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH
`define TOUCH_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ttmf_pkg.sv
// ----------------------------------------------------------------------------
// Touch trimmed-mean filter package
// Shared widths, register indexes, status codes, payload types and helpers.
// ----------------------------------------------------------------------------
package ttmf_pkg;

  localparam int RAW_W      = 16;
  localparam int RAW_SHIFT  = 3;
  localparam int SAMPLE_W   = 13;
  localparam int SUM_W      = 18;
  localparam int GAIN_W     = 16;
  localparam int OFS_W      = 16;
  localparam int SCR_W      = 16;
  localparam int SPREAD_W   = 13;
  localparam int LIMIT_W    = 15;
  localparam int STATUS_W   = 2;
  localparam int PHASE_W    = 2;
  localparam int HELD_DEPTH = 3;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int ACC_W      = PROD_W + 2;

  localparam int SAMPLES_DEF   = 10;
  localparam int GAIN_FRAC_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT    = 3'd5;

  localparam logic [SPREAD_W-1:0]     MAX_SPREAD_RST = 13'd20;
  localparam logic [GAIN_W-1:0]       GAIN_RST       = 16'd256;
  localparam logic signed [OFS_W-1:0] OFFSET_RST     = 16'sd0;
  localparam logic [LIMIT_W-1:0]      X_LIMIT_RST    = 15'd320;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNSTABLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [RAW_W-1:0] raw_word;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]     mean_x;
    logic [SAMPLE_W-1:0]     mean_y;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
    logic [PHASE_W-1:0]  phase;
  } grp_tok_t;

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [SCR_W-1:0] sat_scr(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:SCR_W-1] == '0) || (v[ACC_W-1:SCR_W-1] == '1);
    if (fits) begin
      return v[SCR_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SCR_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SCR_W-1){1'b1}}};
    end
  endfunction

endpackage

### src/touch_trimmed_mean_filter_top.sv
// The word ending the fourth group passes the token, stages c to f and the output register.
// Throughput: one converter word per cycle while in_stall is low, each one added to the group.
// in_stall rises only while a finished result waits in the pipeline and the output is stalled.
// Reset is synchronous on rst_n: config registers return to their defaults, the group restarts
// and the pipeline empties; the held means are not cleared.
// ----------------------------------------------------------------------------
// Touch trimmed-mean filter top level
// Accumulates four groups of samples, forms trimmed means, averages each axis
// and maps the averages to calibrated screen coordinates.
// ----------------------------------------------------------------------------
module touch_trimmed_mean_filter_top import ttmf_pkg::*; #(
  parameter int SAMPLES        = SAMPLES_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int     DIV       = SAMPLES - 2;
  localparam int     DIV_LOG   = $clog2(DIV);
  localparam int     DIV_SHIFT = SUM_W + DIV_LOG;
  localparam int     RECIP_W   = SUM_W + 1;
  localparam int     QPROD_W   = SUM_W + RECIP_W;
  localparam longint RECIP_VAL = ((longint'(1) << DIV_SHIFT) + DIV - 1) / DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic [SPREAD_W-1:0]     max_spread_r;
  logic [GAIN_W-1:0]       x_gain_r, y_gain_r;
  logic signed [OFS_W-1:0] x_offset_r, y_offset_r;
  logic [LIMIT_W-1:0]      x_limit_r;

  logic     adv, out_free, accept;
  logic     tok_valid;
  grp_tok_t tok;

  logic                c_valid_r;
  logic [SUM_W-1:0]    c_trim_r;
  logic [PHASE_W-1:0]  c_phase_r;
  logic                d_valid_r;
  logic [QPROD_W-1:0]  d_prod_r;
  logic [PHASE_W-1:0]  d_phase_r;
  logic [SAMPLE_W-1:0] d_mean;
  logic [SAMPLE_W-1:0] held_r [HELD_DEPTH];
  logic                e_valid_r;
  logic [SAMPLE_W-1:0] e_mx_r, e_my_r;
  logic                e_unstable_r;
  logic                f_valid_r;
  logic [SAMPLE_W-1:0] f_mx_r, f_my_r;
  logic [PROD_W-1:0]   f_px_r, f_py_r;
  logic                f_unstable_r;

  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic signed [SCR_W-1:0] scr_x, scr_y;
  logic [STATUS_W-1:0]     status_nxt;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spread_r <= MAX_SPREAD_RST;
      x_gain_r     <= GAIN_RST;
      x_offset_r   <= OFFSET_RST;
      y_gain_r     <= GAIN_RST;
      y_offset_r   <= OFFSET_RST;
      x_limit_r    <= X_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_SPREAD: max_spread_r <= cfg_wdata[SPREAD_W-1:0];
        CFG_X_GAIN:     x_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_X_OFFSET:   x_offset_r   <= $signed(cfg_wdata[OFS_W-1:0]);
        CFG_Y_GAIN:     y_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_Y_OFFSET:   y_offset_r   <= $signed(cfg_wdata[OFS_W-1:0]);
        CFG_X_LIMIT:    x_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = out_free || !f_valid_r;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  ttmf_accum #(
    .SAMPLES(SAMPLES)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .item     (in_data),
    .tok_valid(tok_valid),
    .tok      (tok)
  );

  assign d_mean = d_prod_r[DIV_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= tok_valid;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r && (d_phase_r == PHASE_LAST);
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_trim_r  <= tok.sum - SUM_W'(tok.min) - SUM_W'(tok.max);
      c_phase_r <= tok.phase;
      d_prod_r  <= QPROD_W'(c_trim_r) * QPROD_W'(RECIP);
      d_phase_r <= c_phase_r;
      if (d_valid_r && (d_phase_r != PHASE_LAST)) begin
        held_r[d_phase_r] <= d_mean;
      end
      e_mx_r       <= SAMPLE_W'(({1'b0, held_r[0]} + {1'b0, held_r[2]}) >> 1);
      e_my_r       <= SAMPLE_W'(({1'b0, held_r[1]} + {1'b0, d_mean}) >> 1);
      e_unstable_r <= (abs_diff(held_r[0], held_r[2]) > max_spread_r) ||
                      (abs_diff(held_r[1], d_mean) > max_spread_r);
      f_mx_r       <= e_mx_r;
      f_my_r       <= e_my_r;
      f_px_r       <= PROD_W'(e_mx_r) * PROD_W'(x_gain_r);
      f_py_r       <= PROD_W'(e_my_r) * PROD_W'(y_gain_r);
      f_unstable_r <= e_unstable_r;
    end
  end

  always_comb begin
    acc_x = $signed({2'b00, f_px_r >> GAIN_FRAC_BITS}) +
            $signed({{(ACC_W-OFS_W){x_offset_r[OFS_W-1]}}, x_offset_r});
    acc_y = $signed({2'b00, f_py_r >> GAIN_FRAC_BITS}) +
            $signed({{(ACC_W-OFS_W){y_offset_r[OFS_W-1]}}, y_offset_r});
    scr_x = sat_scr(acc_x);
    scr_y = sat_scr(acc_y);
    if (f_unstable_r) begin
      status_nxt = STATUS_UNSTABLE;
    end else if (scr_x > $signed({1'b0, x_limit_r})) begin
      status_nxt = STATUS_RANGE;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && f_valid_r) begin
      out_data_r <= '{mean_x: f_mx_r, mean_y: f_my_r, screen_x: scr_x,
                      screen_y: scr_y, status: status_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/ttmf_accum.sv
// ----------------------------------------------------------------------------
// Touch trimmed-mean filter group accumulator
// Keeps the running sum, minimum and maximum of the current group and emits
// a registered group token on the word that completes a group.
// ----------------------------------------------------------------------------
module ttmf_accum import ttmf_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     accept,
  input  in_item_t item,
  output logic     tok_valid,
  output grp_tok_t tok
);

  localparam int CNT_W = $clog2(SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  logic [SUM_W-1:0]    sum_r, sum_base, sum_nxt;
  logic [SAMPLE_W-1:0] min_r, min_base, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_base, max_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_base;
  logic [PHASE_W-1:0]  phase_r, phase_base;
  logic [SAMPLE_W-1:0] sample;
  logic                last;
  logic                tok_valid_r;
  grp_tok_t            tok_r;

  assign sample = item.raw_word[RAW_W-1:RAW_SHIFT];

  always_comb begin
    if (item.restart) begin
      sum_base   = '0;
      min_base   = '1;
      max_base   = '0;
      cnt_base   = '0;
      phase_base = '0;
    end else begin
      sum_base   = sum_r;
      min_base   = min_r;
      max_base   = max_r;
      cnt_base   = cnt_r;
      phase_base = phase_r;
    end
    sum_nxt = sum_base + SUM_W'(sample);
    min_nxt = (sample < min_base) ? sample : min_base;
    max_nxt = (sample > max_base) ? sample : max_base;
    last    = (cnt_base == CNT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      min_r   <= '1;
      max_r   <= '0;
      cnt_r   <= '0;
      phase_r <= '0;
    end else if (accept) begin
      if (last) begin
        sum_r   <= '0;
        min_r   <= '1;
        max_r   <= '0;
        cnt_r   <= '0;
        phase_r <= phase_base + 2'd1;
      end else begin
        sum_r   <= sum_nxt;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        cnt_r   <= cnt_base + CNT_W'(1);
        phase_r <= phase_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (adv) begin
      tok_valid_r <= accept && last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept && last) begin
      tok_r <= '{sum: sum_nxt, min: min_nxt, max: max_nxt, phase: phase_base};
    end
  end

  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

endmodule

### src/ttmf_checker.sv
// ----------------------------------------------------------------------------
// Touch trimmed-mean filter checker
// Port-level assertions on the filter top level, attached by bind.
// ----------------------------------------------------------------------------
`include "touch_trimmed_mean_filter_top_macros.svh"

module ttmf_checker import ttmf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `TTMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result transaction changed while stalled")
  `TTMF_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")
  `TTMF_ASSERT_NOW(a_range_positive, out_valid && (out_data.status == STATUS_RANGE), !out_data.screen_x[SCR_W-1], "range status with negative screen x")

endmodule

bind touch_trimmed_mean_filter_top ttmf_checker u_ttmf_checker (.*);
